>>> hdl/mvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mvm_pkg;

   localparam int MAX_SIZE    = 4096;
   localparam int INDEX_LIMIT = 4096;
   localparam int VEC_DEPTH   = (MAX_SIZE < INDEX_LIMIT) ? MAX_SIZE : INDEX_LIMIT;
   localparam int VEC_AW      = $clog2(VEC_DEPTH);

   localparam int IDX_W  = 12;
   localparam int SIZE_W = 13;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int ACC_W  = 48;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
   localparam logic [SIZE_W-1:0] SIZE_CAP   = SIZE_W'(VEC_DEPTH);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // queue depth between front and back, and of the result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // input command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_MATRIX = 1'b1;

   // operations queued for the back end
   localparam logic OP_VEC_WRITE = 1'b0;
   localparam logic OP_MAC       = 1'b1;

   // register indexes
   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_UPPER_TRI   = 1'b1;

   typedef struct packed {
      logic                    op;
      logic                    last;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic signed [ACC_W-1:0] sum;
      logic                    sat;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/matrix_vector_multiply_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+------------------------
// request   | req_command/row_index/column_index/element_value | req_push & !req_full
// response  | rsp_result_row/row_sum/saturated             | rsp_pop & !rsp_empty
// config    | csr_index, csr_write_data                    | csr_write_enable
//
// One item per cycle sustained while results are popped; after a row's last element
// is accepted it passes the command queue, the vector store read and the multiply register,
// and the saturating accumulate writes the row's result into the result queue.
// The accumulate stage's feedback through the 48-bit saturating add sets the rate.
// Synchronous active-high reset clears queues, pipe valids and the accumulator;
// the vector store is not cleared. The back end stalls when the 4-entry result
// queue cannot take every element in flight; req_full rises once the 4-entry
// command queue fills.
module matrix_vector_multiply_engine_unit
   import mvm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic                    req_command,
   input  wire logic [IDX_W-1:0]        req_row_index,
   input  wire logic [IDX_W-1:0]        req_column_index,
   input  wire logic signed [VAL_W-1:0] req_element_value,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic [IDX_W-1:0]             rsp_result_row,
   output logic signed [ACC_W-1:0]      rsp_row_sum,
   output logic                         rsp_saturated,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_index,
   input  wire logic [SIZE_W-1:0]       csr_write_data
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   mvm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_row_index     (req_row_index),
      .req_column_index  (req_column_index),
      .req_element_value (req_element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   mvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_result_row = rsp.row;
   assign rsp_row_sum    = rsp.sum;
   assign rsp_saturated  = rsp.sat;

endmodule
`default_nettype wire

>>> hdl/mvm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] address,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_data;
      end
      read_data_ff <= mem[address];
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

>>> hdl/mvm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mvm_front
   import mvm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic                    req_command,
   input  wire logic [IDX_W-1:0]        req_row_index,
   input  wire logic [IDX_W-1:0]        req_column_index,
   input  wire logic signed [VAL_W-1:0] req_element_value,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_index,
   input  wire logic [SIZE_W-1:0]       csr_write_data,
   output logic                         cmd_valid,
   output cmd_type                      cmd,
   input  wire logic                    cmd_pop
);

   logic [SIZE_W-1:0]  size_ff;
   logic               tri_ff;
   logic [SIZE_W-1:0]  size_used;
   logic [SIZE_W-1:0]  row_ext;
   logic [SIZE_W-1:0]  col_ext;
   logic               row_ok;
   logic               col_ok;
   logic               keep;
   logic               accept;
   logic               q_push;
   cmd_type            entry;

   cmd_type            q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         tri_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MATRIX_SIZE: size_ff <= csr_write_data;
            CSR_UPPER_TRI:   tri_ff  <= csr_write_data[0];
            default:         size_ff <= size_ff;
         endcase
      end
   end

   // size 0 acts as 1, sizes above the store depth are capped
   always_comb begin
      if (size_ff == '0) begin
         size_used = SIZE_W'(1);
      end else if (size_ff > SIZE_CAP) begin
         size_used = SIZE_CAP;
      end else begin
         size_used = size_ff;
      end
   end

   assign row_ext = {1'b0, req_row_index};
   assign col_ext = {1'b0, req_column_index};
   assign row_ok  = row_ext < size_used;
   assign col_ok  = col_ext < size_used;

   // out-of-range items and elements below the diagonal do nothing: drop them here
   always_comb begin
      if (req_command == CMD_LOAD) begin
         keep = col_ok;
      end else begin
         keep = row_ok && col_ok && !(tri_ff && (req_column_index < req_row_index));
      end
   end

   always_comb begin
      entry.op    = (req_command == CMD_LOAD) ? OP_VEC_WRITE : OP_MAC;
      entry.last  = (col_ext == (size_used - SIZE_W'(1)));
      entry.row   = req_row_index;
      entry.col   = req_column_index;
      entry.value = req_element_value;
   end

   assign req_full = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign accept   = req_push && !req_full;
   assign q_push   = accept && keep;

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(q_push) - Q_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

>>> hdl/mvm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mvm_back
   import mvm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   input  wire cmd_type       cmd,
   output logic               cmd_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output rsp_type            rsp
);

   logic                     issue;
   logic [Q_CNT_W:0]         in_flight;
   logic [VAL_W-1:0]         ram_rdata;

   logic                     s1_valid_ff;
   logic                     s1_last_ff;
   logic [IDX_W-1:0]         s1_row_ff;
   logic signed [VAL_W-1:0]  s1_value_ff;

   logic                     s2_valid_ff;
   logic                     s2_last_ff;
   logic [IDX_W-1:0]         s2_row_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic signed [ACC_W:0]    sum_wide;
   logic                     sum_ovf;
   logic signed [ACC_W-1:0]  sum_sat;

   logic                     r_push;
   rsp_type                  r_entry;
   rsp_type                  r_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]       r_wr_ptr_ff, r_wr_ptr_in;
   logic [Q_PTR_W-1:0]       r_rd_ptr_ff, r_rd_ptr_in;
   logic [Q_CNT_W-1:0]       r_count_ff, r_count_in;
   logic                     r_pop;

   // reserve a result slot for every element in the pipe
   assign in_flight = (Q_CNT_W+1)'(r_count_ff) + (Q_CNT_W+1)'(s1_valid_ff)
                    + (Q_CNT_W+1)'(s2_valid_ff);
   assign issue     = cmd_valid && (in_flight < (Q_CNT_W+1)'(Q_DEPTH));
   assign cmd_pop   = issue;

   mvm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (VEC_DEPTH)
   ) u_vector_store (
      .clock        (clock),
      .write_enable (issue && (cmd.op == OP_VEC_WRITE)),
      .address      (cmd.col[VEC_AW-1:0]),
      .write_data   (cmd.value),
      .read_data    (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue && (cmd.op == OP_MAC);
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= cmd.last;
      s1_row_ff   <= cmd.row;
      s1_value_ff <= cmd.value;
      s2_last_ff  <= s1_last_ff;
      s2_row_ff   <= s1_row_ff;
      s2_prod_ff  <= s1_value_ff * $signed(ram_rdata);
   end

   // one guard bit catches overflow of the 48-bit sum
   always_comb begin
      sum_wide = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(s2_prod_ff);
      sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
      if (!sum_ovf) begin
         sum_sat = sum_wide[ACC_W-1:0];
      end else if (sum_wide[ACC_W]) begin
         sum_sat = ACC_MIN;
      end else begin
         sum_sat = ACC_MAX;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      r_push        = 1'b0;
      r_entry.row   = s2_row_ff;
      r_entry.sum   = sum_sat;
      r_entry.sat   = ovf_ff || sum_ovf;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            r_push = 1'b1;
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = sum_sat;
            ovf_in = ovf_ff || sum_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_empty = (r_count_ff == '0);
   assign r_pop     = rsp_pop && !rsp_empty;
   assign rsp       = r_ff[r_rd_ptr_ff];

   always_comb begin
      r_wr_ptr_in = r_push ? r_wr_ptr_ff + Q_PTR_W'(1) : r_wr_ptr_ff;
      r_rd_ptr_in = r_pop ? r_rd_ptr_ff + Q_PTR_W'(1) : r_rd_ptr_ff;
      r_count_in  = r_count_ff + Q_CNT_W'(r_push) - Q_CNT_W'(r_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_wr_ptr_ff <= '0;
         r_rd_ptr_ff <= '0;
         r_count_ff  <= '0;
      end else begin
         r_wr_ptr_ff <= r_wr_ptr_in;
         r_rd_ptr_ff <= r_rd_ptr_in;
         r_count_ff  <= r_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (r_push) begin
         r_ff[r_wr_ptr_ff] <= r_entry;
      end
   end

endmodule
`default_nettype wire

>>> bench/matrix_vector_multiply_engine_unit_tb.sv
`timescale 1ns / 1ps
module matrix_vector_multiply_engine_unit_tb;
   import mvm_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic                    req_command = CMD_LOAD;
   logic [IDX_W-1:0]        req_row_index = '0;
   logic [IDX_W-1:0]        req_column_index = '0;
   logic signed [VAL_W-1:0] req_element_value = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [IDX_W-1:0]        rsp_result_row;
   logic signed [ACC_W-1:0] rsp_row_sum;
   logic                    rsp_saturated;
   logic                    csr_write_enable = 1'b0;
   logic                    csr_index = CSR_MATRIX_SIZE;
   logic [SIZE_W-1:0]       csr_write_data = '0;

   // shadow copy of the engine state
   logic signed [VAL_W-1:0] vector_copy [VEC_DEPTH];
   bit                      entry_loaded [VEC_DEPTH];
   logic signed [ACC_W-1:0] running_sum = '0;
   bit                      sum_clamped = 1'b0;
   logic [SIZE_W-1:0]       size_setting = SIZE_RESET;
   bit                      triangular_mode = 1'b0;

   rsp_type expected_rows[$];
   int      items_sent = 0;
   int      rows_checked = 0;
   int      saturated_rows = 0;
   int      mismatch_count = 0;
   bit      steady_flow = 1'b0;

   matrix_vector_multiply_engine_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_element_value(req_element_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_row   (rsp_result_row),
      .rsp_row_sum      (rsp_row_sum),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int size_in_effect();
      int n;
      n = int'(size_setting);
      if (n == 0) n = 1;
      if (n > VEC_DEPTH) n = VEC_DEPTH;
      return n;
   endfunction

   // dot-product predictor, called once per accepted item
   function automatic void accumulate_item(logic cmd, logic [IDX_W-1:0] row,
                                           logic [IDX_W-1:0] col,
                                           logic signed [VAL_W-1:0] val);
      int      n;
      longint total;
      rsp_type done;
      n = size_in_effect();
      if (cmd == CMD_LOAD) begin
         if (col < n) begin
            vector_copy[col] = val;
            entry_loaded[col] = 1'b1;
         end
         return;
      end
      if (row >= n || col >= n) return;
      if (!(triangular_mode && col < row)) begin
         total = longint'(running_sum) + longint'(val) * longint'(vector_copy[col]);
         if (total > longint'(ACC_MAX)) begin
            total = longint'(ACC_MAX);
            sum_clamped = 1'b1;
         end else if (total < longint'(ACC_MIN)) begin
            total = longint'(ACC_MIN);
            sum_clamped = 1'b1;
         end
         running_sum = total[ACC_W-1:0];
      end
      if (col != n - 1) return;
      done.row = row;
      done.sum = running_sum;
      done.sat = sum_clamped;
      expected_rows.push_back(done);
      running_sum = '0;
      sum_clamped = 1'b0;
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // push stays high after acceptance; the next call or drain_engine decides
   task automatic send_item(logic cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [VAL_W-1:0] val);
      while (!steady_flow && $urandom_range(99) < 28) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_command <= cmd;
      req_row_index <= row;
      req_column_index <= col;
      req_element_value <= val;
      @(posedge clock);
      while (req_full) @(posedge clock);
      accumulate_item(cmd, row, col, val);
      items_sent++;
   endtask

   task automatic drain_engine();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      // items with no result may still be in the pipe
      repeat (16) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MATRIX_SIZE) size_setting = data;
      else triangular_mode = data[0];
   endtask

   always @(negedge clock) rsp_pop <= steady_flow || ($urandom_range(99) >= 28);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result row=%0d sum=%h sat=%b",
                        rsp_result_row, rsp_row_sum, rsp_saturated);
         end else begin
            want = expected_rows.pop_front();
            rows_checked++;
            if (want.sat) saturated_rows++;
            if (rsp_result_row !== want.row || rsp_row_sum !== want.sum ||
                rsp_saturated !== want.sat) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: expected row=%0d sum=%h sat=%b, got row=%0d sum=%h sat=%b",
                           want.row, want.sum, want.sat,
                           rsp_result_row, rsp_row_sum, rsp_saturated);
            end
         end
      end
   end

   // size and mode straight out of reset: 4096, dense
   task automatic test_reset_defaults();
      send_item(CMD_LOAD, 12'hFFF, 12'd4095, 16'h7FFF);
      send_item(CMD_LOAD, 12'h000, 12'd0, 16'h8000);
      send_item(CMD_MATRIX, 12'd4095, 12'd0, 16'h8000);
      send_item(CMD_MATRIX, 12'd4095, 12'd4095, 16'h7FFF);
   endtask

   task automatic test_directed_cases();
      drain_engine();
      write_register(CSR_MATRIX_SIZE, 13'd3);
      write_register(CSR_UPPER_TRI, 13'd1);
      send_item(CMD_LOAD, 12'hFFF, 12'd0, 16'h0100);
      send_item(CMD_LOAD, 12'h000, 12'd1, 16'hFF00);
      send_item(CMD_LOAD, 12'hABC, 12'd2, 16'h8000);
      send_item(CMD_LOAD, 12'h555, 12'd3, 16'h7FFF);   // beyond size, dropped
      // row 1 skips column 0 in triangular mode
      send_item(CMD_MATRIX, 12'd1, 12'd0, 16'h7FFF);
      send_item(CMD_MATRIX, 12'd1, 12'd1, 16'h8000);
      send_item(CMD_MATRIX, 12'd1, 12'd2, 16'h7FFF);
      send_item(CMD_MATRIX, 12'd0, 12'd0, 16'h8000);
      send_item(CMD_MATRIX, 12'd0, 12'd1, 16'h0001);
      send_item(CMD_MATRIX, 12'd0, 12'd2, 16'hFFFF);
      // out-of-range rows and columns add nothing and close nothing
      send_item(CMD_MATRIX, 12'd3, 12'd2, 16'h7FFF);
      send_item(CMD_MATRIX, 12'd0, 12'd3, 16'h7FFF);
      send_item(CMD_MATRIX, 12'hFFF, 12'hFFF, 16'h8000);
      // rows interleaved into one sum, closed by row 2
      send_item(CMD_MATRIX, 12'd2, 12'd0, 16'h1234);
      send_item(CMD_MATRIX, 12'd0, 12'd1, 16'h0300);
      send_item(CMD_MATRIX, 12'd2, 12'd2, 16'hF000);
      // open a sum at size 3, close it after shrinking to size 2
      send_item(CMD_MATRIX, 12'd0, 12'd0, 16'h0200);
      drain_engine();
      write_register(CSR_MATRIX_SIZE, 13'd2);
      write_register(CSR_UPPER_TRI, 13'd0);
      send_item(CMD_MATRIX, 12'd1, 12'd0, 16'h0100);
      send_item(CMD_MATRIX, 12'd1, 12'd1, 16'h0300);
   endtask

   task automatic test_random_phases();
      int sizes [16] = '{1, 0, 2, 3, 4, 8191, 5, 7, 8, 16, 4096, 31, 4095, 3, 6, 12};
      int n, phase, budget_end, k;
      int sparse_cols[$];
      logic [IDX_W-1:0] row_pick, col_pick;
      logic cmd_pick;
      for (phase = 0; phase < 16; phase++) begin
         drain_engine();
         write_register(CSR_MATRIX_SIZE, SIZE_W'(sizes[phase]));
         write_register(CSR_UPPER_TRI, {12'($urandom), 1'(phase % 2)});
         steady_flow = (phase == 9);
         n = size_in_effect();
         budget_end = items_sent + 125;
         sparse_cols.delete();
         if (n <= 32) begin
            for (k = 0; k < n; k++)
               send_item(CMD_LOAD, IDX_W'($urandom), IDX_W'(k), random_value());
         end else begin
            // large sizes: only a few columns, always including the last one
            sparse_cols.push_back(n - 1);
            repeat (6) sparse_cols.push_back($urandom_range(n - 2));
            foreach (sparse_cols[k])
               send_item(CMD_LOAD, IDX_W'($urandom), IDX_W'(sparse_cols[k]),
                         random_value());
         end
         while (items_sent < budget_end) begin
            if ($urandom_range(99) < 12) begin
               cmd_pick = 1'($urandom);
               row_pick = IDX_W'($urandom);
               if ($urandom_range(1)) col_pick = IDX_W'($urandom);
               else col_pick = IDX_W'($urandom_range(n + 1));
               // never read a vector entry that was not written
               if (row_pick < n && col_pick < n && !entry_loaded[col_pick])
                  cmd_pick = CMD_LOAD;
               send_item(cmd_pick, row_pick, col_pick, random_value());
            end else begin
               row_pick = IDX_W'($urandom_range(n - 1));
               if (n <= 32) begin
                  for (k = 0; k < n; k++)
                     send_item(CMD_MATRIX, row_pick, IDX_W'(k), random_value());
               end else begin
                  repeat ($urandom_range(5))
                     send_item(CMD_MATRIX, row_pick,
                               IDX_W'(sparse_cols[$urandom_range(sparse_cols.size() - 1)]),
                               random_value());
                  send_item(CMD_MATRIX, row_pick, IDX_W'(n - 1), random_value());
               end
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_random_phases();
      drain_engine();
      $display("Summary: %0d items sent, %0d row sums checked (%0d saturated), %0d mismatches",
               items_sent, rows_checked, saturated_rows, mismatch_count);
      $display("Covered sizes 0..8191, dense and triangular modes, out-of-range and mixed rows");
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("ERROR: run timed out");
      $display("Test completed with failures");
      $finish;
   end

endmodule
